// ===== hw/rtl/upi_pkg.sv =====
// shared types and constants of the unicycle pose integrator
// cordic angle table, fixed-point scales, register indexes, state encodings
// no dependencies
`timescale 1ns / 1ps

package upi_pkg;

    // cordic datapath: Q2.30 vectors, binary-angle residue with headroom
    localparam int CORDIC_W   = 33;
    localparam int ANGLE_Z_W  = 34;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [CORDIC_W-1:0]  CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [ANGLE_Z_W-1:0] QUARTER_TURN = 34'sh040000000;
    localparam logic signed [ANGLE_Z_W-1:0] HALF_TURN    = 34'sh080000000;

    // heading increment: Q4.28 rad times round(2^16*8/pi), then drop 16 bits
    localparam int ANGLE_SCALE_W = 19;
    localparam logic signed [ANGLE_SCALE_W-1:0] ANGLE_SCALE = 19'sd166886;
    localparam int HEAD_FRAC = 16;
    localparam int HEAD_W    = 32;

    // step time and position scaling
    localparam int DT_W      = 16;
    localparam int POS_SHIFT = 42;
    localparam int OUT_W     = 32;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CFG_START_X       = 3'd0,
        CFG_START_Y       = 3'd1,
        CFG_START_HEADING = 3'd2,
        CFG_STEP_TIME     = 3'd3,
        CFG_HOLONOMIC     = 3'd4
    } upi_cfg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROTATE,
        BK_MUL_FWD,
        BK_MUL_LAT,
        BK_UPDATE
    } upi_back_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } upi_rot_req_t;

    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [CORDIC_W-1:0] cos_val;
        logic signed [CORDIC_W-1:0] sin_val;
    } upi_trig_t;

    typedef struct packed {
        logic rotating;
        logic at_start;
    } upi_back_status_t;

    function automatic logic signed [ANGLE_Z_W-1:0] cordic_atan(
        input logic [ATAN_IDX_W-1:0] idx
    );
        logic signed [ANGLE_Z_W-1:0] a;
        case (idx)
            5'd0:    a = 34'sh020000000;
            5'd1:    a = 34'sh012E4051E;
            5'd2:    a = 34'sh009FB385B;
            5'd3:    a = 34'sh0051111D4;
            5'd4:    a = 34'sh0028B0D43;
            5'd5:    a = 34'sh00145D7E1;
            5'd6:    a = 34'sh000A2F61E;
            5'd7:    a = 34'sh000517C55;
            5'd8:    a = 34'sh00028BE53;
            5'd9:    a = 34'sh000145F2F;
            5'd10:   a = 34'sh0000A2F98;
            5'd11:   a = 34'sh0000517CC;
            5'd12:   a = 34'sh000028BE6;
            5'd13:   a = 34'sh0000145F3;
            5'd14:   a = 34'sh00000A2FA;
            5'd15:   a = 34'sh00000517D;
            5'd16:   a = 34'sh0000028BE;
            5'd17:   a = 34'sh00000145F;
            5'd18:   a = 34'sh000000A30;
            5'd19:   a = 34'sh000000518;
            5'd20:   a = 34'sh00000028C;
            5'd21:   a = 34'sh000000146;
            5'd22:   a = 34'sh0000000A3;
            5'd23:   a = 34'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/upi_queue.sv =====
// two-entry queue between the front and back parts of the pose integrator
// depends on upi_pkg for the depth
`timescale 1ns / 1ps

module upi_queue #(
    parameter int WIDTH = 99
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(upi_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(upi_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [upi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(upi_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(upi_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(upi_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/upi_front.sv =====
// front part: takes input transactions, clamps velocities, scales them by the
// step time and forms the heading increment; depends on upi_pkg
`timescale 1ns / 1ps

module upi_front #(
    parameter int VEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  forward_speed,
    input  logic signed [15:0]                  lateral_speed,
    input  logic signed [15:0]                  turn_rate,
    input  logic                                final_step,
    input  logic [upi_pkg::DT_W-1:0]            step_time,
    input  logic                                holonomic_mode,
    output logic                                push,
    output logic [2*(VEL_BITS+upi_pkg::DT_W+1)+upi_pkg::HEAD_W:0] push_data,
    input  logic                                push_ready
);

    localparam int VW = VEL_BITS + upi_pkg::DT_W + 1;
    localparam int PW = VW + upi_pkg::ANGLE_SCALE_W;
    localparam logic signed [31:0] VMAX = (32'sd1 <<< (VEL_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] VMIN = -VMAX - 32'sd1;
    localparam logic signed [PW-1:0] HEAD_RND = PW'(1) << (upi_pkg::HEAD_FRAC - 1);

    logic                       s1_valid_reg, s1_valid_next;
    logic signed [VW-1:0]       s1_vfdt_reg, s1_vldt_reg, s1_wzdt_reg;
    logic                       s1_fin_reg;
    logic                       s2_valid_reg, s2_valid_next;
    logic signed [VW-1:0]       s2_vfdt_reg, s2_vldt_reg;
    logic [upi_pkg::HEAD_W-1:0] s2_dhead_reg;
    logic                       s2_fin_reg;

    logic                       accept, s1_move, s2_free;
    logic signed [VEL_BITS-1:0] vf_sat, vl_sat, wz_sat;
    logic signed [VW-1:0]       dt_s;
    logic signed [PW-1:0]       head_prod, head_rnd;

    function automatic logic signed [VEL_BITS-1:0] sat_vel(input logic signed [15:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > VMAX)
        begin
            w = VMAX;
        end
        else if (w < VMIN)
        begin
            w = VMIN;
        end
        return VEL_BITS'(w);
    endfunction

    assign s2_free  = !s2_valid_reg || push_ready;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    assign push      = s2_valid_reg;
    assign push_data = {s2_fin_reg, s2_dhead_reg, s2_vldt_reg, s2_vfdt_reg};

    assign vf_sat = sat_vel(forward_speed);
    assign vl_sat = holonomic_mode ? sat_vel(lateral_speed) : '0;
    assign wz_sat = sat_vel(turn_rate);
    assign dt_s   = VW'($signed({1'b0, step_time}));

    assign head_prod = PW'(s1_wzdt_reg) * PW'(upi_pkg::ANGLE_SCALE);
    assign head_rnd  = head_prod + HEAD_RND;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);
    assign s2_valid_next = s1_move || (s2_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_vfdt_reg <= VW'(vf_sat) * dt_s;
            s1_vldt_reg <= VW'(vl_sat) * dt_s;
            s1_wzdt_reg <= VW'(wz_sat) * dt_s;
            s1_fin_reg  <= final_step;
        end
        if (s1_move)
        begin
            s2_vfdt_reg  <= s1_vfdt_reg;
            s2_vldt_reg  <= s1_vldt_reg;
            s2_dhead_reg <= head_rnd[upi_pkg::HEAD_FRAC +: upi_pkg::HEAD_W];
            s2_fin_reg   <= s1_fin_reg;
        end
    end

endmodule

// ===== hw/rtl/upi_cordic.sv =====
// iterative rotation-mode cordic: one micro-rotation per cycle, yields the
// cosine and sine of a binary angle in Q2.30; depends on upi_pkg
`timescale 1ns / 1ps

module upi_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  upi_pkg::upi_rot_req_t req,
    output upi_pkg::upi_trig_t    trig
);

    localparam int CW     = upi_pkg::CORDIC_W;
    localparam int ZW     = upi_pkg::ANGLE_Z_W;
    localparam int IW     = upi_pkg::ATAN_IDX_W;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 flip_reg, flip_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic signed [ZW-1:0] ang_s, z_fold, atan_val;
    logic                 fold;
    logic signed [CW-1:0] xs, ys, nx, ny;
    logic signed [ZW-1:0] nz;
    logic                 last;

    assign trig.busy    = busy_reg;
    assign trig.done    = done_reg;
    assign trig.cos_val = cos_reg;
    assign trig.sin_val = sin_reg;

    assign ang_s    = ZW'($signed(req.angle));
    assign atan_val = upi_pkg::cordic_atan(IW'(step_reg));
    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign last     = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        fold   = 1'b0;
        z_fold = ang_s;
        if (ang_s > upi_pkg::QUARTER_TURN)
        begin
            fold   = 1'b1;
            z_fold = ang_s - upi_pkg::HALF_TURN;
        end
        else if (ang_s < -upi_pkg::QUARTER_TURN)
        begin
            fold   = 1'b1;
            z_fold = ang_s + upi_pkg::HALF_TURN;
        end
    end

    always_comb
    begin
        if (!z_reg[ZW-1])
        begin
            nx = x_reg - ys;
            ny = y_reg + xs;
            nz = z_reg - atan_val;
        end
        else
        begin
            nx = x_reg + ys;
            ny = y_reg - xs;
            nz = z_reg + atan_val;
        end
    end

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = upi_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = z_fold;
            flip_next = fold;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = nx;
            y_next = ny;
            z_next = nz;
            if (last)
            begin
                step_next = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = flip_reg ? -nx : nx;
                sin_next  = flip_reg ? -ny : ny;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            flip_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

endmodule

// ===== hw/rtl/upi_back.sv =====
// back part: holds the pose, drives the cordic, forms the position step and
// keeps the result register; depends on upi_pkg
`timescale 1ns / 1ps

module upi_back #(
    parameter int POS_BITS = 32,
    parameter int VEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [2*(VEL_BITS+upi_pkg::DT_W+1)+upi_pkg::HEAD_W:0] q_data,
    output logic                                q_pop,
    input  logic signed [31:0]                  start_x,
    input  logic signed [31:0]                  start_y,
    input  logic [31:0]                         start_heading,
    output upi_pkg::upi_rot_req_t               rot_req,
    input  upi_pkg::upi_trig_t                  trig,
    output upi_pkg::upi_back_status_t           status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [31:0]                  pos_x,
    output logic signed [31:0]                  pos_y,
    output logic [31:0]                         heading_out,
    output logic                                final_out
);

    localparam int VW    = VEL_BITS + upi_pkg::DT_W + 1;
    localparam int CW    = upi_pkg::CORDIC_W;
    localparam int ACC_W = VW + CW + 1;
    localparam int HW    = upi_pkg::HEAD_W;
    localparam logic signed [ACC_W-1:0] POS_RND = ACC_W'(1) << (upi_pkg::POS_SHIFT - 1);
    localparam logic signed [63:0] PMAX = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;
    localparam logic signed [63:0] OMAX = (64'sd1 <<< (upi_pkg::OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;

    upi_pkg::upi_back_state_t state_reg, state_next;
    logic                    at_start_reg, at_start_next;
    logic                    out_valid_reg, out_valid_next;

    logic [HW-1:0]           cur_heading_reg, cur_heading_next;
    logic signed [POS_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [VW-1:0]    vfdt_reg, vfdt_next, vldt_reg, vldt_next;
    logic                    fin_reg, fin_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [31:0]      pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0]             heading_reg, heading_next;
    logic                    final_reg, final_next;

    logic [HW-1:0]           base_heading;
    logic signed [POS_BITS-1:0] base_x, base_y, new_x, new_y;
    logic signed [ACC_W-1:0] rnd_x, rnd_y;
    logic signed [63:0]      sum_x, sum_y;
    logic                    out_free;

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v;
        if (w > PMAX)
        begin
            w = PMAX;
        end
        else if (w < PMIN)
        begin
            w = PMIN;
        end
        return POS_BITS'(w);
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [POS_BITS-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > OMAX)
        begin
            w = OMAX;
        end
        else if (w < OMIN)
        begin
            w = OMIN;
        end
        return 32'(w);
    endfunction

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign heading_out = heading_reg;
    assign final_out   = final_reg;

    assign status.rotating = (state_reg == upi_pkg::BK_ROTATE);
    assign status.at_start = at_start_reg;

    assign out_free     = !out_valid_reg || out_ready;
    assign base_heading = at_start_reg ? start_heading : cur_heading_reg;
    assign base_x       = at_start_reg ? sat_pos(64'(start_x)) : cur_x_reg;
    assign base_y       = at_start_reg ? sat_pos(64'(start_y)) : cur_y_reg;

    // round half up at Q.16 and add to the saturating position
    assign rnd_x = acc_x_reg + POS_RND;
    assign rnd_y = acc_y_reg + POS_RND;
    assign sum_x = 64'(cur_x_reg) + 64'(rnd_x >>> upi_pkg::POS_SHIFT);
    assign sum_y = 64'(cur_y_reg) + 64'(rnd_y >>> upi_pkg::POS_SHIFT);
    assign new_x = sat_pos(sum_x);
    assign new_y = sat_pos(sum_y);

    always_comb
    begin
        state_next       = state_reg;
        at_start_next    = at_start_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        q_pop            = 1'b0;
        rot_req.start    = 1'b0;
        rot_req.angle    = base_heading;
        cur_heading_next = cur_heading_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        vfdt_next        = vfdt_reg;
        vldt_next        = vldt_reg;
        fin_next         = fin_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        heading_next     = heading_reg;
        final_next       = final_reg;
        case (state_reg)
            upi_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop            = 1'b1;
                    rot_req.start    = 1'b1;
                    at_start_next    = 1'b0;
                    cur_x_next       = base_x;
                    cur_y_next       = base_y;
                    cur_heading_next = base_heading + q_data[2*VW +: HW];
                    vfdt_next        = $signed(q_data[VW-1:0]);
                    vldt_next        = $signed(q_data[VW +: VW]);
                    fin_next         = q_data[2*VW+HW];
                    state_next       = upi_pkg::BK_ROTATE;
                end
            end
            upi_pkg::BK_ROTATE:
            begin
                if (trig.done)
                begin
                    state_next = upi_pkg::BK_MUL_FWD;
                end
            end
            upi_pkg::BK_MUL_FWD:
            begin
                acc_x_next = ACC_W'(vfdt_reg) * ACC_W'(trig.cos_val);
                acc_y_next = ACC_W'(vfdt_reg) * ACC_W'(trig.sin_val);
                state_next = upi_pkg::BK_MUL_LAT;
            end
            upi_pkg::BK_MUL_LAT:
            begin
                acc_x_next = acc_x_reg - ACC_W'(vldt_reg) * ACC_W'(trig.sin_val);
                acc_y_next = acc_y_reg + ACC_W'(vldt_reg) * ACC_W'(trig.cos_val);
                state_next = upi_pkg::BK_UPDATE;
            end
            upi_pkg::BK_UPDATE:
            begin
                if (out_free)
                begin
                    cur_x_next     = new_x;
                    cur_y_next     = new_y;
                    pos_x_next     = sat_out(new_x);
                    pos_y_next     = sat_out(new_y);
                    heading_next   = cur_heading_reg;
                    final_next     = fin_reg;
                    out_valid_next = 1'b1;
                    if (fin_reg)
                    begin
                        at_start_next = 1'b1;
                    end
                    state_next = upi_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = upi_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upi_pkg::BK_IDLE;
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            at_start_reg  <= at_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_heading_reg <= cur_heading_next;
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        vfdt_reg        <= vfdt_next;
        vldt_reg        <= vldt_next;
        fin_reg         <= fin_next;
        acc_x_reg       <= acc_x_next;
        acc_y_reg       <= acc_y_next;
        pos_x_reg       <= pos_x_next;
        pos_y_reg       <= pos_y_next;
        heading_reg     <= heading_next;
        final_reg       <= final_next;
    end

endmodule

// ===== hw/rtl/unicycle_pose_integrator.sv =====
// Unicycle pose integrator, top level. Each input transaction is one Euler step
// of forward, lateral and turn speed; each produces one result transaction with
// the new x, y (Q16.16, saturated) and heading (binary angle, wraps). The pose
// restarts from the start registers after reset and after a step marked final.
// In the back part each step waits for the iterative cordic that turns the old
// heading into cosine and sine; the front part registers each step in its s1 and
// s2 stages and overlaps with the back part through a two-entry queue, and the
// result register lets the next step start while a result waits. Configuration
// writes are taken in any cycle.
// depends on upi_pkg, upi_front, upi_queue, upi_cordic, upi_back
`timescale 1ns / 1ps

module unicycle_pose_integrator #(
    parameter int POS_BITS     = 32,
    parameter int VEL_BITS     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] forward_speed,
    input  logic signed [15:0] lateral_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               final_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [31:0]        heading_out,
    output logic               final_out
);

    localparam int VW     = VEL_BITS + upi_pkg::DT_W + 1;
    localparam int ITEM_W = 2 * VW + upi_pkg::HEAD_W + 1;

    logic signed [31:0]         start_x_reg, start_y_reg;
    logic [31:0]                start_heading_reg;
    logic [upi_pkg::DT_W-1:0]   step_time_reg;
    logic                       holonomic_reg;
    logic                       cfg_write;

    logic                       q_push, q_push_ready, q_valid, q_pop;
    logic [ITEM_W-1:0]          q_push_data, q_data;
    upi_pkg::upi_rot_req_t      rot_req;
    upi_pkg::upi_trig_t         trig;
    upi_pkg::upi_back_status_t  bk_status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
            step_time_reg     <= 16'd3277;
            holonomic_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                upi_pkg::CFG_START_X:       start_x_reg       <= $signed(cfg_data);
                upi_pkg::CFG_START_Y:       start_y_reg       <= $signed(cfg_data);
                upi_pkg::CFG_START_HEADING: start_heading_reg <= cfg_data;
                upi_pkg::CFG_STEP_TIME:     step_time_reg     <= cfg_data[upi_pkg::DT_W-1:0];
                upi_pkg::CFG_HOLONOMIC:     holonomic_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    upi_front #(
        .VEL_BITS (VEL_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .forward_speed  (forward_speed),
        .lateral_speed  (lateral_speed),
        .turn_rate      (turn_rate),
        .final_step     (final_step),
        .step_time      (step_time_reg),
        .holonomic_mode (holonomic_reg),
        .push           (q_push),
        .push_data      (q_push_data),
        .push_ready     (q_push_ready)
    );

    upi_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    upi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rot_req),
        .trig  (trig)
    );

    upi_back #(
        .POS_BITS (POS_BITS),
        .VEL_BITS (VEL_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .start_heading (start_heading_reg),
        .rot_req       (rot_req),
        .trig          (trig),
        .status        (bk_status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading_out   (heading_out),
        .final_out     (final_out)
    );

`ifndef SYNTHESIS
    // a finished rotation is only reported while the back part waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        trig.done |-> bk_status.rotating)
        else $error("cordic result with no step waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        rot_req.start |-> !trig.busy)
        else $error("cordic restarted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !bk_status.rotating)
        else $error("queue read while empty or mid step");

    // a step marked final re-arms the start pose as its result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && final_out |-> bk_status.at_start)
        else $error("final step did not re-arm start pose");
`endif

endmodule
